// File: rtl/class_map_erosion_3x3_chain_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the class map erosion chain
// Clocked on clk, disabled while rst_n is low; NO_ASSERTIONS removes them.
// ---------------------------------------------------------------------------
`ifndef CLASS_MAP_EROSION_3X3_CHAIN_MACROS_SVH
`define CLASS_MAP_EROSION_3X3_CHAIN_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CME_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define CME_ASSERT_NEVER(lbl, cond) \
  `CME_ASSERT(lbl, !(cond))
`else
`define CME_ASSERT(lbl, prop)
`define CME_ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: rtl/cme_pkg.sv
// ---------------------------------------------------------------------------
// cme_pkg
// Shared types, register indexes and the raster position step.
// ---------------------------------------------------------------------------
package cme_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_PASSES_DEF = 4;

  localparam int ROW_W  = 12;
  localparam int COL_W  = 12;
  localparam int WID_W  = 13;
  localparam int PASS_W = 4;
  localparam int CFG_W  = 12;

  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_EROSION_PASSES = 2'd2;

  localparam logic [10:0] IMAGE_WIDTH_RST    = 11'd640;
  localparam logic [11:0] IMAGE_HEIGHT_RST   = 12'd480;
  localparam logic [2:0]  EROSION_PASSES_RST = 3'd2;

  typedef enum logic [1:0] {
    K_NONE  = 2'd0,
    K_PIX   = 2'd1,
    K_DRAIN = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [1:0]       value;
    logic             own_pos;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } item_t;

  typedef struct packed {
    logic [WID_W-1:0]  width;
    logic [ROW_W-1:0]  height;
    logic [PASS_W-1:0] passes;
    logic              flush;
  } cfg_t;

  typedef struct packed {
    logic           active;
    logic [COL_W:0] addr;
  } clr_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

  function automatic pos_t advance(pos_t p, logic [WID_W-1:0] w, logic [ROW_W-1:0] h);
    pos_t n;
    n = p;
    if ({1'b0, p.col} + 13'd1 >= w) begin
      n.col = '0;
      n.row = ({1'b0, p.row} + 13'd1 >= {1'b0, h}) ? '0 : p.row + 12'd1;
    end else begin
      n.col = p.col + 12'd1;
    end
    return n;
  endfunction

endpackage

// File: rtl/cme_fifo.sv
// ---------------------------------------------------------------------------
// cme_fifo
// Small register queue; read data is the oldest word, shown while not empty.
// ---------------------------------------------------------------------------
`include "class_map_erosion_3x3_chain_macros.svh"
module cme_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `CME_ASSERT(a_count_bound, count_r <= CW'(DEPTH))

endmodule

// File: rtl/cme_front.sv
// ---------------------------------------------------------------------------
// cme_front
// Config registers, line store clearing sweep and input word classification.
// ---------------------------------------------------------------------------
`include "class_map_erosion_3x3_chain_macros.svh"
module cme_front
  import cme_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_PASSES = MAX_PASSES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_operation,
  input  logic [1:0]       in_pixel_class,
  input  logic             in_frame_start,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             q_full,
  output logic             q_push,
  output item_t            q_item,
  output cfg_t             cfg,
  output clr_t             clr
);

  logic [10:0]    width_r;
  logic [11:0]    height_r;
  logic [2:0]     passes_r;
  logic           clr_active_r;
  logic [COL_W:0] clr_addr_r;
  logic           cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
                              cfg_index == REG_IMAGE_HEIGHT ||
                              cfg_index == REG_EROSION_PASSES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= IMAGE_WIDTH_RST;
      height_r     <= IMAGE_HEIGHT_RST;
      passes_r     <= EROSION_PASSES_RST;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:    width_r  <= cfg_data[10:0];
          REG_IMAGE_HEIGHT:   height_r <= cfg_data[11:0];
          REG_EROSION_PASSES: passes_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      // sweep covers the valid delay line, one entry longer than a row
      if (cfg_hit) begin
        clr_active_r <= 1'b1;
        clr_addr_r   <= '0;
      end else if (clr_active_r) begin
        if (clr_addr_r == (COL_W+1)'(MAX_WIDTH)) begin
          clr_active_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + (COL_W+1)'(1);
        end
      end
    end
  end

  always_comb begin
    if ({2'b0, width_r} < 13'd3) begin
      cfg.width = 13'd3;
    end else if ({2'b0, width_r} > WID_W'(MAX_WIDTH)) begin
      cfg.width = WID_W'(MAX_WIDTH);
    end else begin
      cfg.width = {2'b0, width_r};
    end
    cfg.height = (height_r < 12'd3) ? 12'd3 : height_r;
    cfg.passes = ({1'b0, passes_r} > PASS_W'(MAX_PASSES)) ? PASS_W'(MAX_PASSES)
                                                           : {1'b0, passes_r};
    cfg.flush  = cfg_hit;
  end

  assign clr.active = clr_active_r;
  assign clr.addr   = clr_addr_r;

  assign in_full = clr_active_r || q_full;
  assign q_push  = in_push && !in_full;

  always_comb begin
    q_item         = '0;
    q_item.kind    = in_operation ? K_DRAIN : K_PIX;
    q_item.value   = in_operation ? 2'd0 : in_pixel_class;
    // frame start pins the position to the origin, else stage 0 counts
    q_item.own_pos = !in_operation && !in_frame_start;
  end

  `CME_ASSERT(a_cfg_blocks_input, cfg_hit |=> in_full)

endmodule

// File: rtl/cme_stage.sv
// ---------------------------------------------------------------------------
// cme_stage
// One 3x3 erosion pass: line store read, then window update and decision.
// ---------------------------------------------------------------------------
`include "class_map_erosion_3x3_chain_macros.svh"
module cme_stage
  import cme_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int STAGE     = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  cfg_t  cfg,
  input  clr_t  clr,
  input  item_t in_item,
  output item_t out_item
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int DW = $clog2(MAX_WIDTH + 1);
  localparam int FW = $clog2(MAX_WIDTH + 2);

  logic [3:0] ls_mem [MAX_WIDTH];
  logic       vd_mem [MAX_WIDTH + 1];

  pos_t          pos_r, pos_nxt, cur;
  logic [DW-1:0] head_r;
  logic [FW-1:0] fill_r, fill_eff;
  logic [1:0]    win_r [3][3];
  logic [1:0]    nw    [3][3];
  item_t         s1_item_r, s1_nxt, out_r, out_nxt;
  logic          s1_take_r, s1_valid_r, take_nxt, valid_nxt;
  logic [3:0]    rd_q, ls_wdata;
  logic          old_q;
  logic          active, all_set, border;
  logic [1:0]    top, mid;
  logic [WID_W-1:0] sub, mr_wide;
  logic [ROW_W-1:0] mr;
  logic [COL_W-1:0] mc;

  assign active   = PASS_W'(STAGE) < cfg.passes;
  assign fill_eff = fill_r + FW'(s1_take_r && s1_valid_r) - FW'(s1_take_r && old_q);

  // front half: position, drain decision, delay line slot
  always_comb begin
    s1_nxt         = in_item;
    s1_nxt.own_pos = 1'b0;
    take_nxt       = 1'b0;
    valid_nxt      = 1'b0;
    pos_nxt        = pos_r;
    cur.row        = in_item.own_pos ? pos_r.row : in_item.row;
    cur.col        = in_item.own_pos ? pos_r.col : in_item.col;
    if (active) begin
      case (in_item.kind)
        K_PIX: begin
          take_nxt   = 1'b1;
          valid_nxt  = 1'b1;
          s1_nxt.row = cur.row;
          s1_nxt.col = cur.col;
          pos_nxt    = advance(cur, cfg.width, cfg.height);
        end
        K_DRAIN: begin
          // an empty pass hands the drain word on untouched
          if (fill_eff != '0) begin
            take_nxt     = 1'b1;
            s1_nxt.value = 2'd0;
            s1_nxt.row   = pos_r.row;
            s1_nxt.col   = pos_r.col;
            pos_nxt      = advance(pos_r, cfg.width, cfg.height);
          end
        end
        default: ;
      endcase
    end else if (STAGE == 0 && cfg.passes == '0 && in_item.kind == K_PIX) begin
      // no passes: only the side columns are cleared
      s1_nxt.row = cur.row;
      s1_nxt.col = cur.col;
      pos_nxt    = advance(cur, cfg.width, cfg.height);
      if (cur.col == '0 || {1'b0, cur.col} >= cfg.width - 13'd1) begin
        s1_nxt.value = 2'd0;
      end
    end
  end

  // back half: window shift and erosion decision
  always_comb begin
    top = rd_q[3:2];
    mid = rd_q[1:0];
    for (int i = 0; i < 3; i++) begin
      nw[i][0] = win_r[i][1];
      nw[i][1] = win_r[i][2];
    end
    nw[0][2] = top;
    nw[1][2] = mid;
    nw[2][2] = s1_item_r.value;
    all_set  = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (nw[i][j] == 2'd0) all_set = 1'b0;
      end
    end
    ls_wdata = {mid, s1_item_r.value};

    // result lies one row and one column behind the input
    if (s1_item_r.col == '0) begin
      mc  = COL_W'(cfg.width - 13'd1);
      sub = 13'd2;
    end else begin
      mc  = s1_item_r.col - 12'd1;
      sub = 13'd1;
    end
    if ({1'b0, s1_item_r.row} >= sub) begin
      mr_wide = {1'b0, s1_item_r.row} - sub;
    end else begin
      mr_wide = {1'b0, s1_item_r.row} + {1'b0, cfg.height} - sub;
    end
    mr     = mr_wide[ROW_W-1:0];
    border = (mr == '0) || (mr >= cfg.height - 12'd1) ||
             (mc == '0) || ({1'b0, mc} >= cfg.width - 13'd1);

    out_nxt = s1_item_r;
    if (s1_take_r) begin
      out_nxt.kind  = old_q ? K_PIX : K_NONE;
      out_nxt.value = (border || !all_set) ? 2'd0 : nw[1][1];
      out_nxt.row   = mr;
      out_nxt.col   = mc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.flush) begin
      pos_r      <= '0;
      head_r     <= '0;
      fill_r     <= '0;
      s1_item_r  <= '0;
      s1_take_r  <= 1'b0;
      s1_valid_r <= 1'b0;
      out_r      <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= 2'd0;
        end
      end
    end else if (en) begin
      pos_r      <= pos_nxt;
      fill_r     <= fill_eff;
      s1_item_r  <= s1_nxt;
      s1_take_r  <= take_nxt;
      s1_valid_r <= valid_nxt;
      out_r      <= out_nxt;
      if (take_nxt) begin
        head_r <= (WID_W'(head_r) >= cfg.width) ? '0 : head_r + DW'(1);
      end
      if (s1_take_r) begin
        win_r <= nw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr.active) begin
      if (clr.addr < (COL_W+1)'(MAX_WIDTH)) begin
        ls_mem[clr.addr[AW-1:0]] <= 4'd0;
      end
      vd_mem[clr.addr[DW-1:0]] <= 1'b0;
    end else if (en) begin
      if (s1_take_r) begin
        ls_mem[s1_item_r.col[AW-1:0]] <= ls_wdata;
      end
      if (take_nxt) begin
        // same column written by the word ahead: take its data
        rd_q <= (s1_take_r && s1_item_r.col == s1_nxt.col) ? ls_wdata
                                                             : ls_mem[s1_nxt.col[AW-1:0]];
        old_q <= vd_mem[head_r];
        vd_mem[head_r] <= valid_nxt;
      end
    end
  end

  assign out_item = out_r;

  `CME_ASSERT(a_old_counted, (s1_take_r && old_q) |-> (fill_r != '0))
  `CME_ASSERT(a_fill_bound, {1'b0, WID_W'(fill_r)} <= {1'b0, cfg.width} + 14'd1)

endmodule

// File: rtl/class_map_erosion_3x3_chain.sv
// ---------------------------------------------------------------------------
// class_map_erosion_3x3_chain
// Takes one word per cycle while in_full is low and the result queue has room;
// a word passes through all MAX_PASSES stages whatever the pass count, and each
// active pass also holds width+1 words in its delay line before its result
// comes out. Reset or a config write starts a line store clearing sweep of
// MAX_WIDTH+1 entries with in_full high; reset is synchronous, active low.
// ---------------------------------------------------------------------------
module class_map_erosion_3x3_chain
  import cme_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_PASSES = MAX_PASSES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_operation,
  input  logic [1:0]       in_pixel_class,
  input  logic             in_frame_start,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [1:0]       out_eroded_class,
  output logic             out_last_of_frame,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int IW = $bits(item_t);

  cfg_t          cfg;
  clr_t          clr;
  logic          q_push, q_full, q_empty, q_pop;
  item_t         q_item;
  logic [IW-1:0] q_rdata;
  logic          en, o_full, o_push;
  logic [2:0]    o_wdata, o_rdata;
  item_t         chain [MAX_PASSES + 1];
  item_t         last_item;

  cme_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_PASSES(MAX_PASSES)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_operation(in_operation), .in_pixel_class(in_pixel_class),
    .in_frame_start(in_frame_start),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_full(q_full), .q_push(q_push), .q_item(q_item),
    .cfg(cfg), .clr(clr)
  );

  cme_fifo #(.WIDTH(IW), .DEPTH(4)) u_mid_q (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .wdata(q_item), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  // whole pass chain moves together while the result queue has room
  assign en    = !o_full;
  assign q_pop = en && !q_empty;

  always_comb begin
    chain[0] = q_empty ? item_t'('0) : item_t'(q_rdata);
  end

  for (genvar k = 0; k < MAX_PASSES; k++) begin : g_pass
    cme_stage #(.MAX_WIDTH(MAX_WIDTH), .STAGE(k)) u_stage (
      .clk(clk), .rst_n(rst_n), .en(en), .cfg(cfg), .clr(clr),
      .in_item(chain[k]), .out_item(chain[k+1])
    );
  end

  assign last_item = chain[MAX_PASSES];
  assign o_push    = en && last_item.kind == K_PIX;
  assign o_wdata   = {last_item.value,
                      (last_item.row == cfg.height - 12'd1) &&
                      ({1'b0, last_item.col} == cfg.width - 13'd1)};

  cme_fifo #(.WIDTH(3), .DEPTH(4)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(o_push), .wdata(o_wdata), .full(o_full),
    .pop(out_pop), .rdata(o_rdata), .empty(out_empty)
  );

  assign out_eroded_class  = o_rdata[2:1];
  assign out_last_of_frame = o_rdata[0];

endmodule
